// ===== rtl/ssw_pkg.sv =====
`timescale 1ns / 1ps
package ssw_pkg;

  localparam int MAX_ROWS   = 4096;
  localparam int MAX_COLS   = 4096;
  localparam int ELEM_W     = 16;
  localparam int LANES      = 4;
  localparam int IN_W       = LANES * ELEM_W;
  localparam int ADDR_W     = 24;
  localparam int OUT_W      = ELEM_W + ADDR_W;
  localparam int DIM_W      = 13;
  localparam int ROW_W      = 12;
  localparam int GRP_W      = 10;
  localparam int WIN_W      = 8;
  localparam int WNZ_W      = 5;
  localparam int META_W     = 16;
  localparam int META_SLOTS = 8;
  localparam int WNZ_CAP    = 16;
  localparam int OFF_W      = 14;
  localparam int MLO_W      = 13;
  localparam int SLOTS      = LANES + 1;
  localparam int CNT_W      = 3;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    REG_TRANSPOSE = 2'd0,
    REG_ROWS      = 2'd1,
    REG_COLS      = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_VALUE = 1'b0,
    KIND_META  = 1'b1
  } res_kind_t;

  typedef logic [ELEM_W-1:0] elem_t;

  // Clamped sizes as seen by the datapath
  typedef struct packed {
    logic             transpose;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [WIN_W:0]   windows;
  } ssw_cfg_t;

  typedef struct packed {
    elem_t [LANES-1:0] elem;
    logic [LANES-1:0]  nz;
    logic [ROW_W-1:0]  row;
    logic [DIM_W-1:0]  kept;
    logic [WIN_W-1:0]  win;
    logic              meta_emit;
    logic [META_W-1:0] meta;
  } trk_item_t;

  typedef struct packed {
    elem_t [LANES-1:0]            elem;
    logic [LANES-1:0]             nz;
    logic                         meta_emit;
    logic [META_W-1:0]            meta;
    logic [ADDR_W-1:0]            val_base;
    logic [ADDR_W-1:0]            meta_base;
    logic [LANES-1:0][OFF_W-1:0]  val_off;
    logic [MLO_W-1:0]             meta_lo;
  } addr_item_t;

  typedef struct packed {
    res_kind_t         kind;
    elem_t             data;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } result_t;

  // Both signed zeros count as zero
  function automatic logic is_nonzero(elem_t v);
    return v[ELEM_W-2:0] != '0;
  endfunction

endpackage

// ===== rtl/ssw_track.sv =====
`timescale 1ns / 1ps
module ssw_track import ssw_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  ssw_cfg_t        cfg,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic            s1_take,
  output logic            s1_vld,
  output trk_item_t       s1_item
);

  logic [ROW_W-1:0]  row_r;
  logic [GRP_W-1:0]  grp_r;
  logic [DIM_W-1:0]  kept_r;
  logic [WNZ_W-1:0]  wnz_r;
  logic [META_W-1:0] meta_r;
  logic              s1_vld_r;
  trk_item_t         s1_item_r;

  elem_t [LANES-1:0] elem;
  logic [LANES-1:0]  nz;
  logic [WNZ_W-1:0]  slot;
  logic [META_W-1:0] meta_nxt;
  logic [WNZ_W-1:0]  wnz_nxt;
  logic [2:0]        nnz;
  logic [WIN_W-1:0]  win;
  logic              win_end;
  logic              row_end;
  logic [DIM_W-1:0]  row_inc;
  logic              in_fire;

  assign in_tready = !s1_vld_r || s1_take;
  assign in_fire   = in_tvalid && in_tready;
  assign win       = grp_r[GRP_W-1:2];
  assign win_end   = grp_r[1:0] == 2'b11;
  assign row_end   = ({1'b0, win} + 9'd1) >= cfg.windows;
  assign row_inc   = {1'b0, row_r} + 13'd1;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      elem[i] = in_tdata[i*ELEM_W +: ELEM_W];
      nz[i]   = is_nonzero(elem[i]);
    end
  end

  // Pack lane positions into the metadata slots in arrival order
  always_comb begin
    meta_nxt = meta_r;
    slot     = wnz_r;
    nnz      = '0;
    for (int i = 0; i < LANES; i++) begin
      if (nz[i]) begin
        if (slot < WNZ_W'(META_SLOTS)) begin
          meta_nxt[{slot[2:0], 1'b0} +: 2] = meta_nxt[{slot[2:0], 1'b0} +: 2] | 2'(i);
        end
        slot = slot + 5'd1;
        nnz  = nnz + 3'd1;
      end
    end
    wnz_nxt = (slot > WNZ_W'(WNZ_CAP)) ? WNZ_W'(WNZ_CAP) : slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      grp_r  <= '0;
      kept_r <= '0;
      wnz_r  <= '0;
      meta_r <= '0;
    end else if (in_fire) begin
      if (win_end) begin
        meta_r <= '0;
        wnz_r  <= '0;
        if (row_end) begin
          grp_r  <= '0;
          kept_r <= '0;
          row_r  <= (row_inc >= cfg.rows) ? '0 : row_inc[ROW_W-1:0];
        end else begin
          grp_r  <= grp_r + 10'd1;
          kept_r <= kept_r + DIM_W'(nnz);
        end
      end else begin
        meta_r <= meta_nxt;
        wnz_r  <= wnz_nxt;
        grp_r  <= grp_r + 10'd1;
        kept_r <= kept_r + DIM_W'(nnz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.elem      <= elem;
      s1_item_r.nz        <= nz;
      s1_item_r.row       <= row_r;
      s1_item_r.kept      <= kept_r;
      s1_item_r.win       <= win;
      s1_item_r.meta_emit <= win_end;
      s1_item_r.meta      <= meta_nxt;
    end
  end

  assign s1_vld  = s1_vld_r;
  assign s1_item = s1_item_r;

endmodule

// ===== rtl/ssw_addr.sv =====
`timescale 1ns / 1ps
module ssw_addr import ssw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ssw_cfg_t   cfg,
  input  logic       s1_vld,
  input  trk_item_t  s1_item,
  output logic       s1_take,
  input  logic       load_ok,
  output logic       s2_vld,
  output addr_item_t s2_item
);

  logic [2*DIM_W-1:0]           prod_t;
  logic [ROW_W+DIM_W-1:0]       prod_n;
  logic [WIN_W+DIM_W-2:0]       prod_m;
  logic [LANES-1:0][1:0]        ord;
  logic [LANES-1:0][OFF_W-1:0]  off;
  logic [OFF_W-1:0]             rows_x;
  logic                         s2_vld_r;
  addr_item_t                   s2_item_r;
  logic [ROW_W-1:0]             r;

  assign s1_take = !s2_vld_r || load_ok;
  assign r       = s1_item.row;

  assign prod_t = s1_item.kept * cfg.rows;
  assign prod_n = s1_item.row * cfg.cols;
  assign prod_m = s1_item.win[WIN_W-1:1] * cfg.rows;

  // Value offset from the lane's rank among this word's nonzeros
  always_comb begin
    ord[0] = 2'd0;
    for (int i = 1; i < LANES; i++) begin
      ord[i] = ord[i-1] + 2'(s1_item.nz[i-1]);
    end
    for (int i = 0; i < LANES; i++) begin
      case (ord[i])
        2'd0:    rows_x = '0;
        2'd1:    rows_x = OFF_W'(cfg.rows);
        2'd2:    rows_x = OFF_W'({cfg.rows, 1'b0});
        2'd3:    rows_x = OFF_W'(cfg.rows) + OFF_W'({cfg.rows, 1'b0});
        default: rows_x = '0;
      endcase
      if (cfg.transpose) begin
        off[i] = OFF_W'(s1_item.row) + rows_x;
      end else begin
        off[i] = OFF_W'(s1_item.kept) + OFF_W'(ord[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s1_take) begin
      s2_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_vld) begin
      s2_item_r.elem      <= s1_item.elem;
      s2_item_r.nz        <= s1_item.nz;
      s2_item_r.meta_emit <= s1_item.meta_emit;
      s2_item_r.meta      <= s1_item.meta;
      s2_item_r.val_base  <= cfg.transpose ? prod_t[ADDR_W-1:0] : ADDR_W'(prod_n[ROW_W+DIM_W-1:1]);
      s2_item_r.meta_base <= ADDR_W'({prod_m, 1'b0});
      s2_item_r.val_off   <= off;
      // Interleaved row order with the parity swap folded in
      s2_item_r.meta_lo   <= {r[11:5], r[2:0], r[4], s1_item.win[0], r[3]};
    end
  end

  assign s2_vld  = s2_vld_r;
  assign s2_item = s2_item_r;

endmodule

// ===== rtl/ssw_emit.sv =====
`timescale 1ns / 1ps
module ssw_emit import ssw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s2_vld,
  input  addr_item_t s2_item,
  output logic       load_ok,
  output logic       res_vld,
  input  logic       res_rdy,
  output result_t    res
);

  result_t [SLOTS-1:0]           cand;
  logic [SLOTS-1:0]              cand_v;
  logic [SLOTS-1:0][CNT_W-1:0]   ord;
  logic [CNT_W-1:0]              n;
  result_t [SLOTS-1:0]           slot_nxt;
  result_t [SLOTS-1:0]           slot_r;
  logic [CNT_W-1:0]              cnt_r;
  logic                          fire;
  logic                          load;

  assign fire    = res_vld && res_rdy;
  assign load_ok = (cnt_r == '0) || (cnt_r == CNT_W'(1) && res_rdy);
  assign load    = load_ok && s2_vld;

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      cand[c].kind = KIND_VALUE;
      cand[c].data = s2_item.elem[c];
      cand[c].addr = s2_item.val_base + ADDR_W'(s2_item.val_off[c]);
      cand[c].last = 1'b0;
      cand_v[c]    = s2_item.nz[c];
    end
    cand[LANES].kind = KIND_META;
    cand[LANES].data = s2_item.meta;
    cand[LANES].addr = s2_item.meta_base + ADDR_W'(s2_item.meta_lo);
    cand[LANES].last = 1'b0;
    cand_v[LANES]    = s2_item.meta_emit;
  end

  // Compact the present results to the head of the queue
  always_comb begin
    ord[0] = '0;
    for (int c = 1; c < SLOTS; c++) begin
      ord[c] = ord[c-1] + CNT_W'(cand_v[c-1]);
    end
    n = ord[SLOTS-1] + CNT_W'(cand_v[SLOTS-1]);
    for (int k = 0; k < SLOTS; k++) begin
      slot_nxt[k] = '0;
      for (int c = 0; c < SLOTS; c++) begin
        if (cand_v[c] && ord[c] == CNT_W'(k)) begin
          slot_nxt[k] = cand[c];
        end
      end
      slot_nxt[k].last = (CNT_W'(k) == n - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= n;
    end else if (fire) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Advance the queue by one word per handshake
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= slot_nxt;
    end else if (fire) begin
      for (int k = 0; k < SLOTS-1; k++) begin
        slot_r[k] <= slot_r[k+1];
      end
    end
  end

  assign res_vld = cnt_r != '0;
  assign res     = slot_r[0];

endmodule

// ===== rtl/structured_sparse_weight_compressor.sv =====
`timescale 1ns / 1ps
// 2:4 structured sparsity weight compressor. Each input word carries four fp16
// weights of one row (row-major order); every nonzero weight (both signed zeros
// count as zero) leaves as a value word with its value store address, and every
// fourth input word also closes a 16-column window with its 16-bit metadata word
// at the interleaved metadata address. tlast marks the final word an input word
// causes; an input word with no nonzero weight that ends no window causes none.
// Three pipeline registers (counter capture, address multipliers, result queue)
// lie between input handshake and first result. Throughput is set by the single
// result channel: the next input word loads only once the queue is empty or its
// last result is leaving. Write the row_count (0x4), col_count (0x8) and
// transpose_layout (0x0) registers only while idle.
module structured_sparse_weight_compressor import ssw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,     // elem0, elem1, elem2, elem3
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,    // data[15:0], address[39:16]
  output logic               out_tuser,    // kind
  output logic               out_tlast,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  logic             transpose_r;
  logic [DIM_W-1:0] row_count_r;
  logic [DIM_W-1:0] col_count_r;
  logic             cfg_wr;
  cfg_reg_t         cfg_sel;
  ssw_cfg_t         cfg;
  logic             s1_vld;
  logic             s1_take;
  trk_item_t        s1_item;
  logic             s2_vld;
  logic             load_ok;
  addr_item_t       s2_item;
  result_t          res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transpose_r <= 1'b0;
      row_count_r <= DIM_W'(32);
      col_count_r <= DIM_W'(16);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_TRANSPOSE: transpose_r <= cfg_pwdata[0];
        REG_ROWS:      row_count_r <= cfg_pwdata[DIM_W-1:0];
        REG_COLS:      col_count_r <= cfg_pwdata[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_TRANSPOSE: cfg_prdata = PDATA_W'(transpose_r);
      REG_ROWS:      cfg_prdata = PDATA_W'(row_count_r);
      REG_COLS:      cfg_prdata = PDATA_W'(col_count_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Clamp sizes; a row has at least one window
  always_comb begin
    cfg.transpose = transpose_r;
    cfg.rows      = (row_count_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : row_count_r;
    cfg.cols      = (col_count_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : col_count_r;
    cfg.windows   = (cfg.cols[DIM_W-1:4] == '0) ? 9'd1 : cfg.cols[DIM_W-1:4];
  end

  ssw_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .s1_take   (s1_take),
    .s1_vld    (s1_vld),
    .s1_item   (s1_item)
  );

  ssw_addr u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .s1_vld  (s1_vld),
    .s1_item (s1_item),
    .s1_take (s1_take),
    .load_ok (load_ok),
    .s2_vld  (s2_vld),
    .s2_item (s2_item)
  );

  ssw_emit u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .s2_vld  (s2_vld),
    .s2_item (s2_item),
    .load_ok (load_ok),
    .res_vld (out_tvalid),
    .res_rdy (out_tready),
    .res     (res)
  );

  assign out_tdata = {res.addr, res.data};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== rtl/ssw_checker.sv =====
`timescale 1ns / 1ps
module ssw_checker import ssw_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_W-1:0]   out_tdata,
  input logic               out_tuser,
  input logic               out_tlast
);

  // Reset empties the result queue
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word pending straight after reset");

  // A metadata word always closes the burst of its input word
  a_meta_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_META |-> out_tlast)
    else $error("metadata word without tlast");

  // A kept value is never a signed zero
  a_value_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_VALUE |-> out_tdata[ELEM_W-2:0] != '0)
    else $error("zero weight emitted as value word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result word changed");

endmodule

bind structured_sparse_weight_compressor ssw_checker u_ssw_checker (.*);

// ===== tb/tb_structured_sparse_weight_compressor.sv =====
`timescale 1ns / 1ps
module tb_structured_sparse_weight_compressor;
  import ssw_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int DIR_ROWS    = 24;
  localparam int PHASES      = 6;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;     // elem0, elem1, elem2, elem3
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;    // data[15:0], address[39:16]
  logic               out_tuser;    // kind
  logic               out_tlast;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  structured_sparse_weight_compressor u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  typedef struct packed {
    logic [IN_W-1:0]   word;
    logic              known;
    logic [1:0]        n;
    logic [ELEM_W-1:0] d0;
    logic [ADDR_W-1:0] a0;
    logic [ELEM_W-1:0] d1;
    logic [ADDR_W-1:0] a1;
  } dir_row_t;

  typedef struct packed {
    logic             transpose;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [15:0]      count;
  } phase_t;

  // Group layout: elem3, elem2, elem1, elem0 from the top
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{64'hFFFF_8000_0000_3C00, 1'b1, 2'd2, 16'h3C00, 24'd0, 16'hFFFF, 24'd1},
    '{64'h8000_0000_8000_0000, 1'b1, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h8001_0001_7E00_7C00, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'hFC00_0000_7FFF_0000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0000_0000_5678_1234, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h8001_ABCD_0000_0000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0000_8000_0000_0000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0000_7BFF_8000_0000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0001_0000_0000_8400, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0000_C000_4000_0000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0AAA_0000_0000_3555, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0001_FFFF_5555_AAAA, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'hFC00_7C00_7FFF_8001, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'hFE00_7E00_8400_0400, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h8888_4444_2222_1111, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h8000_0000_8000_0000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0000_8000_0000_8000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h8000_8000_8000_8000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'hFFFF_8000_0000_0000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h4000_0000_0000_C000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0000_0000_0000_0000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h0000_BC00_3C00_0000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0},
    '{64'h8000_8000_8000_8000, 1'b0, 2'd0, 16'h0, 24'd0, 16'h0, 24'd0}
  };

  // Sizes 8191 check the clamp; 40 columns leave a partial window unused
  localparam phase_t PHASE_TAB [PHASES] = '{
    '{1'b1, 13'd3,    13'd32,   16'd30},
    '{1'b0, 13'd4096, 13'd4096, 16'd25},
    '{1'b1, 13'd8191, 13'd8191, 16'd15},
    '{1'b0, 13'd1,    13'd16,   16'd20},
    '{1'b0, 13'd64,   13'd16,   16'd140},
    '{1'b1, 13'd4096, 13'd40,   16'd20}
  };

  localparam logic [ELEM_W-1:0] SPECIALS [10] = '{
    16'h0000, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h7C00,
    16'hFC00, 16'h7E00, 16'h0001, 16'h8001, 16'h3C00
  };

  // Shadow of the register file
  logic             cfg_transpose;
  logic [DIM_W-1:0] cfg_rows;
  logic [DIM_W-1:0] cfg_cols;

  // Shadow of the block's counters
  logic [ROW_W-1:0]  cur_row;
  logic [GRP_W-1:0]  cur_group;
  logic [DIM_W-1:0]  kept_in_row;
  logic [WNZ_W-1:0]  window_nz;
  logic [META_W-1:0] meta_word;

  result_t group_words [$];
  result_t due_words [$];
  int      errors;
  int      quiet;
  int      stall_left;
  bit      steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Append a word to the tail of a list
  function automatic void add_group_word(input result_t w);
    group_words.insert(group_words.size(), w);
  endfunction

  function automatic void add_due_word(input result_t w);
    due_words.insert(due_words.size(), w);
  endfunction

  // Work out the words one group causes and advance the counters
  function automatic void compress_group(input logic [IN_W-1:0] word);
    logic [63:0]       rows_e;
    logic [63:0]       cols_e;
    logic [63:0]       wins;
    logic [63:0]       r;
    logic [63:0]       w;
    logic [63:0]       a;
    logic [63:0]       drow;
    logic [63:0]       dcol;
    logic [ELEM_W-1:0] v;
    result_t           res;
    group_words.delete();
    rows_e = (64'(cfg_rows) > MAX_ROWS) ? 64'(MAX_ROWS) : 64'(cfg_rows);
    cols_e = (64'(cfg_cols) > MAX_COLS) ? 64'(MAX_COLS) : 64'(cfg_cols);
    wins = cols_e / 16;
    if (wins == 0) wins = 1;
    r = 64'(cur_row);
    w = 64'(cur_group) / 4;
    for (int i = 0; i < LANES; i++) begin
      v = word[ELEM_W*i +: ELEM_W];
      if (v[ELEM_W-2:0] != '0) begin
        if (cfg_transpose) a = 64'(kept_in_row) * rows_e + r;
        else a = (r * cols_e) / 2 + 64'(kept_in_row);
        res.kind = KIND_VALUE;
        res.data = v;
        res.addr = a[ADDR_W-1:0];
        res.last = 1'b0;
        add_group_word(res);
        // slots beyond the eighth fall off the word
        if (window_nz < META_SLOTS) meta_word = meta_word | (16'(i) << (2 * window_nz));
        if (window_nz < WNZ_CAP) window_nz = window_nz + 1'b1;
        kept_in_row = kept_in_row + 1'b1;
      end
    end
    if (cur_group % 4 == 3) begin
      drow = (r / 32) * 32 + (r % 8) * 4 + (r % 32) / 8;
      dcol = w;
      // swap the parities of row and column, moving them in opposite directions
      if (drow[0] == 1'b0 && dcol[0] == 1'b1) begin
        drow = drow + 1;
        dcol = dcol - 1;
      end else if (drow[0] == 1'b1 && dcol[0] == 1'b0) begin
        drow = drow - 1;
        dcol = dcol + 1;
      end
      a = (dcol / 2) * rows_e * 2 + drow * 2 + dcol % 2;
      res.kind = KIND_META;
      res.data = meta_word;
      res.addr = a[ADDR_W-1:0];
      res.last = 1'b0;
      add_group_word(res);
      meta_word = '0;
      window_nz = '0;
      if (w + 1 >= wins) begin
        cur_group = '0;
        kept_in_row = '0;
        cur_row = (r + 1 >= rows_e) ? '0 : ROW_W'(r + 1);
      end else begin
        cur_group = cur_group + 1'b1;
      end
    end else begin
      cur_group = cur_group + 1'b1;
    end
    if (group_words.size() > 0) group_words[group_words.size()-1].last = 1'b1;
  endfunction

  function automatic logic [IN_W-1:0] random_group();
    logic [IN_W-1:0]   word;
    logic [ELEM_W-1:0] v;
    int                pick;
    int                p0;
    int                p1;
    pick = $urandom_range(0, 99);
    p0 = $urandom_range(0, 3);
    p1 = (p0 + $urandom_range(1, 3)) % 4;
    for (int i = 0; i < LANES; i++) begin
      v = 16'($urandom);
      if (v[ELEM_W-2:0] == '0) v[0] = 1'b1;
      if (pick < 60) begin
        // well-formed two of four, zeros of either sign
        if (i != p0 && i != p1) v = {v[15], 15'b0};
      end else if (pick < 75) begin
        if ($urandom_range(0, 1) == 1) v = {v[15], 15'b0};
      end else if (pick < 85) begin
        v = {v[15], 15'b0};
      end else if (pick < 93) begin
        v = 16'($urandom);
      end else begin
        v = SPECIALS[$urandom_range(0, 9)];
      end
      word[ELEM_W*i +: ELEM_W] = v;
    end
    return word;
  endfunction

  task automatic send_group(input logic [IN_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    compress_group(word);
  endtask

  // Hold the sender until every due word is back, then let the pipe empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [PDATA_W-1:0] val);
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    cfg_pwrite  <= 1'b1;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_TRANSPOSE: cfg_transpose = val[0];
      REG_ROWS:      cfg_rows = val[DIM_W-1:0];
      REG_COLS:      cfg_cols = val[DIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_words.size() == 0) begin
        $error("word with none due: kind %0d data %h address %h", out_tuser,
               out_tdata[15:0], out_tdata[39:16]);
        errors++;
      end else begin
        want = due_words.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          errors++;
        end
        if (out_tdata[15:0] !== want.data) begin
          $error("data: expected %h, got %h", want.data, out_tdata[15:0]);
          errors++;
        end
        if (out_tdata[39:16] !== want.addr) begin
          $error("address: expected %h, got %h", want.addr, out_tdata[39:16]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    result_t rw;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    errors      = 0;
    quiet       = 0;
    stall_left  = 0;
    steady      = 1'b0;
    cfg_transpose = 1'b0;
    cfg_rows      = 13'd32;
    cfg_cols      = 13'd16;
    cur_row       = '0;
    cur_group     = '0;
    kept_in_row   = '0;
    window_nz     = '0;
    meta_word     = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++) begin
      send_group(DIR_TAB[k].word);
      if (DIR_TAB[k].known) begin
        for (int j = 0; j < DIR_TAB[k].n; j++) begin
          rw.kind = KIND_VALUE;
          rw.data = (j == 0) ? DIR_TAB[k].d0 : DIR_TAB[k].d1;
          rw.addr = (j == 0) ? DIR_TAB[k].a0 : DIR_TAB[k].a1;
          rw.last = (j == DIR_TAB[k].n - 1);
          add_due_word(rw);
        end
      end else begin
        foreach (group_words[j]) add_due_word(group_words[j]);
      end
    end

    // Counters carry across each change of sizes
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_TRANSPOSE, 32'(PHASE_TAB[ph].transpose));
      write_reg(REG_ROWS, 32'(PHASE_TAB[ph].rows));
      write_reg(REG_COLS, 32'(PHASE_TAB[ph].cols));
      for (int k = 0; k < PHASE_TAB[ph].count; k++) begin
        steady = (ph == 4 && k >= 30 && k < 70);
        send_group(random_group());
        foreach (group_words[j]) add_due_word(group_words[j]);
        if (!steady && $urandom_range(0, 24) == 0) drain();
      end
      steady = 1'b0;
    end
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
